// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the point bearing and distance block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define PBA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: label");

// Assertion that also holds through reset.
`define PBA_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed: label");

`endif

// ----- sv/pba_pkg.sv -----
// ----------------------------------------------------------------------------
// pba_pkg
// Types, widths, constants and the arctangent table of the bearing unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pba_pkg;

   localparam int COORD_WIDTH    = 24;
   localparam int ROTATION_STEPS = 16;

   localparam int GUARD     = 8;
   localparam int TABLE_LEN = 24;
   localparam int STEP_W    = $clog2(TABLE_LEN);

   // CORDIC x and y: magnitude of the difference, guard bits, gain headroom, sign.
   localparam int XW      = COORD_WIDTH + GUARD + 3;
   // Angle accumulator in Q.24 radians.
   localparam int ZW      = 28;
   localparam int DIST_W  = 25;
   localparam int BEAR_W  = 16;
   localparam int MAG_W   = COORD_WIDTH + 1;
   localparam int GAIN_W  = 30;
   localparam int LO_W    = 16;
   localparam int HI_W    = XW - 1 - LO_W;

   localparam logic [GAIN_W-1:0]       INV_GAIN_Q30 = GAIN_W'(652032874);
   localparam logic signed [ZW-1:0]    PI_Q24       = ZW'(52707179);
   localparam logic signed [BEAR_W-1:0] PI_Q13      = BEAR_W'(25736);
   localparam logic signed [BEAR_W-1:0] HALF_PI_Q13 = BEAR_W'(12868);
   localparam logic [DIST_W-1:0]       DIST_MAX     = {DIST_W{1'b1}};

   typedef struct packed {
      logic signed [XW-1:0]     x;
      logic signed [XW-1:0]     y;
      logic signed [ZW-1:0]     z;
      logic                     special;
      logic [DIST_W-1:0]        spec_dist;
      logic signed [BEAR_W-1:0] spec_bear;
   } pba_vec_type;

   // atan(2^-i) in Q.24 radians, rounded.
   function automatic logic signed [ZW-1:0] atan_q24(input logic [STEP_W-1:0] idx);
      logic signed [ZW-1:0] a;
      unique case (idx)
         5'd0:  a = ZW'(13176795);
         5'd1:  a = ZW'(7778716);
         5'd2:  a = ZW'(4110060);
         5'd3:  a = ZW'(2086331);
         5'd4:  a = ZW'(1047214);
         5'd5:  a = ZW'(524117);
         5'd6:  a = ZW'(262123);
         5'd7:  a = ZW'(131069);
         5'd8:  a = ZW'(65536);
         5'd9:  a = ZW'(32768);
         5'd10: a = ZW'(16384);
         5'd11: a = ZW'(8192);
         5'd12: a = ZW'(4096);
         5'd13: a = ZW'(2048);
         5'd14: a = ZW'(1024);
         5'd15: a = ZW'(512);
         5'd16: a = ZW'(256);
         5'd17: a = ZW'(128);
         5'd18: a = ZW'(64);
         5'd19: a = ZW'(32);
         5'd20: a = ZW'(16);
         5'd21: a = ZW'(8);
         5'd22: a = ZW'(4);
         5'd23: a = ZW'(2);
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

// ----- sv/pba_req_if.sv -----
// ----------------------------------------------------------------------------
// pba_req_if
// Request channel: a start point and an end point in signed Q16.8.
// ----------------------------------------------------------------------------
`default_nettype none

interface pba_req_if;
   import pba_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] from_x;
   logic signed [COORD_WIDTH-1:0] from_y;
   logic signed [COORD_WIDTH-1:0] to_x;
   logic signed [COORD_WIDTH-1:0] to_y;

   modport source (output valid, output from_x, output from_y, output to_x,
                   output to_y, input ready);
   modport sink   (input valid, input from_x, input from_y, input to_x,
                   input to_y, output ready);
endinterface

`default_nettype wire

// ----- sv/pba_rsp_if.sv -----
// ----------------------------------------------------------------------------
// pba_rsp_if
// Response channel: distance in unsigned Q17.8 and bearing in Q3.13 radians.
// ----------------------------------------------------------------------------
`default_nettype none

interface pba_rsp_if;
   import pba_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [DIST_W-1:0]        distance;
   logic signed [BEAR_W-1:0] bearing;

   modport source (output valid, output distance, output bearing, input ready);
   modport sink   (input valid, input distance, input bearing, output ready);
endinterface

`default_nettype wire

// ----- sv/pba_entry.sv -----
// ----------------------------------------------------------------------------
// pba_entry
// Forms the difference vector, folds it into the right half plane and
// resolves the axis-aligned cases, whose results bypass the rotation chain.
// ----------------------------------------------------------------------------
`default_nettype none

module pba_entry (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   in_valid,
   output logic                                        in_ready,
   input  wire logic signed [pba_pkg::COORD_WIDTH-1:0] from_x,
   input  wire logic signed [pba_pkg::COORD_WIDTH-1:0] from_y,
   input  wire logic signed [pba_pkg::COORD_WIDTH-1:0] to_x,
   input  wire logic signed [pba_pkg::COORD_WIDTH-1:0] to_y,
   output logic                                        out_valid,
   input  wire logic                                   out_ready,
   output pba_pkg::pba_vec_type                        out_data
);
   import pba_pkg::*;

   localparam int CMP_W = (MAG_W > DIST_W) ? MAG_W : DIST_W;

   logic signed [MAG_W-1:0] dx, dy;
   logic [MAG_W-1:0]        dx_mag, dy_mag, axis_mag;
   logic                    dx_neg, dy_neg, dx_zero, dy_zero;
   logic signed [XW-1:0]    y_mag_ext;
   pba_vec_type             vec_in;
   pba_vec_type             vec_ff;
   logic                    valid_ff;

   always_comb begin
      dx      = {to_x[COORD_WIDTH-1], to_x} - {from_x[COORD_WIDTH-1], from_x};
      dy      = {to_y[COORD_WIDTH-1], to_y} - {from_y[COORD_WIDTH-1], from_y};
      dx_neg  = dx[MAG_W-1];
      dy_neg  = dy[MAG_W-1];
      dx_zero = (dx == '0);
      dy_zero = (dy == '0);
      dx_mag  = dx_neg ? MAG_W'(-dx) : MAG_W'(dx);
      dy_mag  = dy_neg ? MAG_W'(-dy) : MAG_W'(dy);

      // Left half plane vectors are mirrored through the origin and the
      // accumulator starts at plus or minus pi.
      vec_in.x  = signed'(XW'({dx_mag, {GUARD{1'b0}}}));
      y_mag_ext = signed'(XW'({dy_mag, {GUARD{1'b0}}}));
      vec_in.y  = (dy_neg ^ dx_neg) ? -y_mag_ext : y_mag_ext;
      if (dx_neg) begin
         vec_in.z = dy_neg ? -PI_Q24 : PI_Q24;
      end else begin
         vec_in.z = '0;
      end

      vec_in.special = dx_zero || dy_zero;
      axis_mag       = dx_zero ? dy_mag : dx_mag;
      if (CMP_W'(axis_mag) > CMP_W'(DIST_MAX)) begin
         vec_in.spec_dist = DIST_MAX;
      end else begin
         vec_in.spec_dist = DIST_W'(axis_mag);
      end
      priority if (dx_zero && dy_zero) begin
         vec_in.spec_bear = '0;
      end else if (dx_zero) begin
         vec_in.spec_bear = dy_neg ? -HALF_PI_Q13 : HALF_PI_Q13;
      end else begin
         vec_in.spec_bear = dx_neg ? PI_Q13 : '0;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = vec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         vec_ff <= vec_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/pba_cell.sv -----
// ----------------------------------------------------------------------------
// pba_cell
// One vectoring micro-rotation of the CORDIC chain with its stage register.
// ----------------------------------------------------------------------------
`default_nettype none

module pba_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [pba_pkg::STEP_W-1:0]    step,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire pba_pkg::pba_vec_type          in_data,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output pba_pkg::pba_vec_type               out_data
);
   import pba_pkg::*;

   logic signed [XW-1:0] xs, ys;
   logic signed [ZW-1:0] angle;
   pba_vec_type          vec_in;
   pba_vec_type          vec_ff;
   logic                 valid_ff;

   always_comb begin
      xs     = in_data.x >>> step;
      ys     = in_data.y >>> step;
      angle  = atan_q24(step);
      vec_in = in_data;
      // Rotate toward the x axis: the sign of y picks the direction.
      if (!in_data.y[XW-1]) begin
         vec_in.x = in_data.x + ys;
         vec_in.y = in_data.y - xs;
         vec_in.z = in_data.z + angle;
      end else begin
         vec_in.x = in_data.x - ys;
         vec_in.y = in_data.y + xs;
         vec_in.z = in_data.z - angle;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = vec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         vec_ff <= vec_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/pba_scale.sv -----
// ----------------------------------------------------------------------------
// pba_scale
// Removes the CORDIC gain from the magnitude, rounds and wraps the angle and
// holds the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module pba_scale (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  in_valid,
   output logic                                       in_ready,
   input  wire pba_pkg::pba_vec_type                  in_data,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [pba_pkg::DIST_W-1:0]                 rsp_distance,
   output logic signed [pba_pkg::BEAR_W-1:0]          rsp_bearing
);
   import pba_pkg::*;

   localparam int T_W   = HI_W + GAIN_W;
   localparam int U_W   = LO_W + GAIN_W;
   localparam int S_W   = T_W + 1;
   localparam int D_W   = S_W - 22;
   localparam int CMP_W = (D_W > DIST_W) ? D_W : DIST_W;

   localparam logic signed [ZW-1:0] BEAR_RND   = ZW'(1024);
   localparam logic signed [ZW-1:0] PI_Z       = ZW'(25736);
   localparam logic signed [ZW-1:0] TWO_PI_Z   = ZW'(51472);
   localparam logic [S_W-1:0]       DIST_RND   = S_W'(2 ** 21);

   // Multiply stage
   logic [XW-2:0]            x_pos;
   logic [T_W-1:0]           t_in, t_ff;
   logic [U_W-1:0]           u_in, u_ff;
   logic signed [ZW-1:0]     z_rnd;
   logic signed [BEAR_W-1:0] bear_in, bear_ff;
   logic                     special_ff;
   logic [DIST_W-1:0]        spec_dist_ff;
   logic                     mul_valid_ff;
   logic                     mul_ready;

   // Response stage
   logic [S_W-1:0]           sum;
   logic [D_W-1:0]           dist_raw;
   logic [DIST_W-1:0]        dist_in, dist_ff;
   logic signed [BEAR_W-1:0] bearing_ff;
   logic                     valid_ff;

   always_comb begin
      x_pos = in_data.x[XW-1] ? '0 : in_data.x[XW-2:0];
      t_in  = T_W'(x_pos[XW-2:LO_W]) * T_W'(INV_GAIN_Q30);
      u_in  = U_W'(x_pos[LO_W-1:0]) * U_W'(INV_GAIN_Q30);

      z_rnd = (in_data.z + BEAR_RND) >>> 11;
      priority if (in_data.special) begin
         bear_in = in_data.spec_bear;
      end else if (z_rnd > PI_Z) begin
         bear_in = BEAR_W'(z_rnd - TWO_PI_Z);
      end else if (z_rnd <= -PI_Z) begin
         bear_in = BEAR_W'(z_rnd + TWO_PI_Z);
      end else begin
         bear_in = BEAR_W'(z_rnd);
      end
   end

   assign in_ready  = !mul_valid_ff || mul_ready;
   assign mul_ready = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (in_ready) begin
         mul_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         t_ff         <= t_in;
         u_ff         <= u_in;
         bear_ff      <= bear_in;
         special_ff   <= in_data.special;
         spec_dist_ff <= in_data.spec_dist;
      end
   end

   always_comb begin
      sum      = S_W'(t_ff) + S_W'(u_ff[U_W-1:LO_W]) + DIST_RND;
      dist_raw = sum[S_W-1:22];
      priority if (special_ff) begin
         dist_in = spec_dist_ff;
      end else if (CMP_W'(dist_raw) > CMP_W'(DIST_MAX)) begin
         dist_in = DIST_MAX;
      end else begin
         dist_in = DIST_W'(dist_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (mul_ready) begin
         valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready && mul_valid_ff) begin
         dist_ff    <= dist_in;
         bearing_ff <= bear_ff;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_distance = dist_ff;
   assign rsp_bearing  = bearing_ff;

endmodule

`default_nettype wire

// ----- sv/point_bearing_and_distance.sv -----
// ----------------------------------------------------------------------------
// point_bearing_and_distance
// Distance and bearing between two Q16.8 points by a pipelined CORDIC.
// ----------------------------------------------------------------------------
// Each request carries a start and an end point; the response gives the
// rounded Euclidean distance (unsigned Q17.8, saturating) and the bearing
// from start to end in Q3.13 radians within (-pi, pi]. A new request can be
// taken every cycle while the response is not stalled. The pipeline has one
// entry stage, one cell per micro-rotation in the CORDIC chain, a gain
// multiply stage and the response register. Every stage holds its own valid
// bit, so a stalled response lets requests fill the empty stages behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module point_bearing_and_distance (
   input  wire logic  clock,
   input  wire logic  reset,
   pba_req_if.sink    req,
   pba_rsp_if.source  rsp
);
   import pba_pkg::*;

   logic [ROTATION_STEPS:0] chain_valid;
   logic [ROTATION_STEPS:0] chain_ready;
   pba_vec_type             chain_data [ROTATION_STEPS+1];

   pba_entry u_entry (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .from_x    (req.from_x),
      .from_y    (req.from_y),
      .to_x      (req.to_x),
      .to_y      (req.to_y),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   for (genvar i = 0; i < ROTATION_STEPS; i++) begin : g_cell
      pba_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step      (STEP_W'(i)),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   pba_scale u_scale (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (chain_valid[ROTATION_STEPS]),
      .in_ready     (chain_ready[ROTATION_STEPS]),
      .in_data      (chain_data[ROTATION_STEPS]),
      .rsp_valid    (rsp.valid),
      .rsp_ready    (rsp.ready),
      .rsp_distance (rsp.distance),
      .rsp_bearing  (rsp.bearing)
   );

endmodule

`default_nettype wire

// ----- sv/pba_checker.sv -----
// ----------------------------------------------------------------------------
// pba_checker
// Port-level checks of the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pba_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_ready,
   input wire logic [pba_pkg::DIST_W-1:0]           rsp_distance,
   input wire logic signed [pba_pkg::BEAR_W-1:0]    rsp_bearing
);
   import pba_pkg::*;

   // A stalled response must keep its valid and its payload.
   `PBA_ASSERT(rsp_valid_held, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `PBA_ASSERT(rsp_payload_held, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_distance) && $stable(rsp_bearing))

   // The bearing is always wrapped into the half-open interval.
   `PBA_ASSERT(bearing_in_range, clock, reset, rsp_valid |-> (rsp_bearing <= PI_Q13) && (rsp_bearing > -PI_Q13))

   // Only equal points come out with no distance, and those have no bearing.
   `PBA_ASSERT(zero_distance_zero_bearing, clock, reset, rsp_valid && (rsp_distance == '0) |-> (rsp_bearing == '0))

   // The pipeline is empty on the cycle after reset.
   `PBA_ASSERT_ALWAYS(empty_after_reset, clock, $past(reset) |-> !rsp_valid)

endmodule

bind point_bearing_and_distance pba_checker u_pba_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_distance (rsp.distance),
   .rsp_bearing  (rsp.bearing)
);

`default_nettype wire
